[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the sleep controller blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property at every rising edge outside reset
`define ADSC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sleep controller assertion failed");
// Check that a condition is followed by a result in the next cycle
`define ADSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sleep controller assertion failed");
`else
`define ADSC_ASSERT(lbl, clk, rstn, prop)
`define ADSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[hw/rtl/adsc_pkg.sv]
// ----------------------------------------------------------------------------
// adsc_pkg
// Shared widths, codes and bundles of the activity-driven sleep controller.
// ----------------------------------------------------------------------------
package adsc_pkg;

  localparam int TIME_W = 32;
  localparam int HOLD_W = 16;
  localparam int DUTY_W = 7;
  localparam int CNT_W  = 16;
  localparam int PROD_W = DUTY_W + HOLD_W;
  localparam int ADDR_W = 3;
  localparam int CFG_DW = 32;
  localparam int IN_W   = 48;
  localparam int OUT_W  = 88;

  // Dwell in sleep-soon before going sleepy
  localparam logic [TIME_W-1:0] SOON_DWELL_MS = TIME_W'(500);
  // Percent scale of the duty setting
  localparam logic [6:0]        PCT_SCALE     = 7'd100;

  // Register reset values
  localparam logic [DUTY_W-1:0] DUTY_RST      = 7'd10;
  localparam logic [HOLD_W-1:0] PERIOD_RST    = 16'd100;
  localparam logic [TIME_W-1:0] MAX_SLEEP_RST = TIME_W'(10000);
  localparam logic [HOLD_W-1:0] INIT_HOLD_RST = 16'd10000;
  localparam logic [HOLD_W-1:0] DEF_ACT_RST   = 16'd5000;
  localparam logic [PROD_W-1:0] PROD_RST      = PROD_W'(1000);

  typedef enum logic [2:0] {
    MODE_INIT   = 3'd0,
    MODE_ACTIVE = 3'd1,
    MODE_SOON   = 3'd2,
    MODE_SLEEPY = 3'd3,
    MODE_DOZE   = 3'd4
  } pwr_mode_t;

  typedef enum logic [ADDR_W-1:0] {
    REG_ENABLE    = 3'd0,
    REG_DUTY      = 3'd1,
    REG_SLEEP_LEN = 3'd2,
    REG_PERIOD    = 3'd3,
    REG_MAX_SLEEP = 3'd4,
    REG_INIT_HOLD = 3'd5,
    REG_DEF_ACT   = 3'd6
  } cfg_reg_t;

  // Settings seen by the state machine
  typedef struct packed {
    logic              enable;
    logic [HOLD_W-1:0] period;
    logic [TIME_W-1:0] max_sleep;
    logic [HOLD_W-1:0] init_hold;
    logic [HOLD_W-1:0] def_active;
    logic [PROD_W-1:0] doze_prod;   // period * duty, before the percent scale
  } cfg_t;

  // One result word
  typedef struct packed {
    logic [CNT_W-1:0]  doze_total;
    logic [TIME_W-1:0] asleep_time_ms;
    logic [TIME_W-1:0] awake_time_ms;
    logic              forced_wake;
    logic              sleep_request;
    pwr_mode_t         power_state;
  } res_t;

endpackage

[hw/rtl/adsc_cfg.sv]
// ----------------------------------------------------------------------------
// adsc_cfg
// Setting registers and the pre-scaled doze interval product.
// ----------------------------------------------------------------------------
module adsc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [adsc_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [adsc_pkg::CFG_DW-1:0]  cfg_wdata,
  output adsc_pkg::cfg_t               cfg
);
  import adsc_pkg::*;

  logic              enable_r;
  logic [DUTY_W-1:0] duty_r;
  logic [HOLD_W-1:0] period_r;
  logic [TIME_W-1:0] max_sleep_r;
  logic [HOLD_W-1:0] init_hold_r;
  logic [HOLD_W-1:0] def_active_r;
  logic [PROD_W-1:0] prod_r;

  logic [DUTY_W-1:0] mul_duty;
  logic [HOLD_W-1:0] mul_period;
  logic [PROD_W-1:0] prod_nxt;
  logic              prod_upd;

  // Take the new operand from the write port, the other from its register
  always_comb begin
    mul_duty   = (cfg_addr == REG_DUTY)   ? cfg_wdata[DUTY_W-1:0] : duty_r;
    mul_period = (cfg_addr == REG_PERIOD) ? cfg_wdata[HOLD_W-1:0] : period_r;
    prod_nxt   = PROD_W'(mul_duty) * PROD_W'(mul_period);
    prod_upd   = cfg_we && ((cfg_addr == REG_DUTY) || (cfg_addr == REG_PERIOD));
  end

  // Hold the registers; the sleep length feeds no result and is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      duty_r       <= DUTY_RST;
      period_r     <= PERIOD_RST;
      max_sleep_r  <= MAX_SLEEP_RST;
      init_hold_r  <= INIT_HOLD_RST;
      def_active_r <= DEF_ACT_RST;
      prod_r       <= PROD_RST;
    end else begin
      if (prod_upd) begin
        prod_r <= prod_nxt;
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_ENABLE:    enable_r     <= cfg_wdata[0];
          REG_DUTY:      duty_r       <= cfg_wdata[DUTY_W-1:0];
          REG_SLEEP_LEN: ;
          REG_PERIOD:    period_r     <= cfg_wdata[HOLD_W-1:0];
          REG_MAX_SLEEP: max_sleep_r  <= cfg_wdata[TIME_W-1:0];
          REG_INIT_HOLD: init_hold_r  <= cfg_wdata[HOLD_W-1:0];
          REG_DEF_ACT:   def_active_r <= cfg_wdata[HOLD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cfg.enable     = enable_r;
    cfg.period     = period_r;
    cfg.max_sleep  = max_sleep_r;
    cfg.init_hold  = init_hold_r;
    cfg.def_active = def_active_r;
    cfg.doze_prod  = prod_r;
  end

endmodule

[hw/rtl/adsc_fsm.sv]
// ----------------------------------------------------------------------------
// adsc_fsm
// Power state machine, activity hold, doze counter and the two stopwatches.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adsc_fsm (
  input  logic                         clk,
  input  logic                         rst_n,
  input  adsc_pkg::cfg_t               cfg,
  input  logic                         step,
  input  logic [adsc_pkg::TIME_W-1:0]  now,
  input  logic [adsc_pkg::HOLD_W-1:0]  radio,
  output adsc_pkg::res_t               res
);
  import adsc_pkg::*;

  pwr_mode_t         mode_r, mode_nxt;
  logic [TIME_W-1:0] entry_r, entry_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0] a_st_r, a_st_nxt, a_en_r, a_en_nxt;
  logic              a_run_r, a_run_nxt;
  logic [TIME_W-1:0] s_st_r, s_st_nxt, s_en_r, s_en_nxt;
  logic              s_run_r, s_run_nxt;

  logic [TIME_W-1:0] in_mode;
  logic [TIME_W:0]   in_mode_p1;
  logic [39:0]       doze_scaled;
  logic              doze_due;
  logic [TIME_W-1:0] limit_prod;
  logic              limit_hit;
  logic              radio_hit;
  logic              chg;
  pwr_mode_t         tgt;
  logic              req;
  logic              forced;

  // Elapsed time in the current mode and the limit checks
  always_comb begin
    in_mode     = now - entry_r;
    in_mode_p1  = {1'b0, in_mode} + (TIME_W+1)'(1);
    doze_scaled = 40'(in_mode_p1) * 40'(PCT_SCALE);
    // in_mode >= max(prod / 100, 1)
    doze_due    = (in_mode != '0) && (40'(cfg.doze_prod) < doze_scaled);
    limit_prod  = TIME_W'(cnt_r) * TIME_W'(cfg.period);
    limit_hit   = limit_prod > cfg.max_sleep;
    radio_hit   = radio != '0;
  end

  // Pick the transition for this poll
  always_comb begin
    chg    = 1'b0;
    tgt    = mode_r;
    req    = 1'b0;
    forced = 1'b0;
    if (cfg.enable) begin
      case (mode_r)
        MODE_INIT: begin
          if (in_mode > TIME_W'(cfg.init_hold)) begin
            chg = 1'b1;
            tgt = MODE_ACTIVE;
          end
        end
        MODE_ACTIVE: begin
          if (!radio_hit && (in_mode > TIME_W'(hold_r))) begin
            chg = 1'b1;
            tgt = MODE_SOON;
          end
        end
        MODE_SOON: begin
          if (radio_hit) begin
            chg = 1'b1;
            tgt = MODE_ACTIVE;
          end else if (in_mode > SOON_DWELL_MS) begin
            chg = 1'b1;
            tgt = MODE_SLEEPY;
          end
        end
        MODE_SLEEPY: begin
          chg = 1'b1;
          if (radio_hit) begin
            tgt = MODE_ACTIVE;
          end else begin
            req = 1'b1;
            if (limit_hit) begin
              tgt    = MODE_ACTIVE;
              forced = 1'b1;
            end else begin
              tgt = MODE_DOZE;
            end
          end
        end
        MODE_DOZE: begin
          if (radio_hit) begin
            chg = 1'b1;
            tgt = MODE_ACTIVE;
          end else if (doze_due) begin
            chg = 1'b1;
            tgt = MODE_SLEEPY;
          end
        end
        default: ;
      endcase
    end
  end

  // Work out the state after the poll
  always_comb begin
    mode_nxt  = mode_r;
    entry_nxt = entry_r;
    hold_nxt  = hold_r;
    cnt_nxt   = cnt_r;
    a_st_nxt  = a_st_r;
    a_en_nxt  = a_en_r;
    a_run_nxt = a_run_r;
    s_st_nxt  = s_st_r;
    s_en_nxt  = s_en_r;
    s_run_nxt = s_run_r;
    if (!cfg.enable) begin
      entry_nxt = now;
    end else begin
      // grow the activity hold
      if (radio_hit && (radio > hold_r)) begin
        hold_nxt = radio;
      end
      // activity in active restarts the mode timer
      if ((mode_r == MODE_ACTIVE) && radio_hit) begin
        entry_nxt = now;
      end
      if (chg) begin
        mode_nxt  = tgt;
        entry_nxt = now;
        // resume the awake stopwatch
        if (!a_run_r) begin
          a_st_nxt = now - (a_en_r - a_st_r);
        end
        a_run_nxt = 1'b1;
        // leaving sleepy stops the asleep stopwatch
        if (mode_r == MODE_SLEEPY) begin
          if (s_run_r) begin
            s_en_nxt = now;
          end
          s_run_nxt = 1'b0;
        end
        // entering sleepy swaps the stopwatches and restores the hold
        if (tgt == MODE_SLEEPY) begin
          hold_nxt  = cfg.def_active;
          a_en_nxt  = now;
          a_run_nxt = 1'b0;
          if (!s_run_r) begin
            s_st_nxt = now - (s_en_r - s_st_r);
          end
          s_run_nxt = 1'b1;
        end
        if ((tgt == MODE_DOZE) && (cnt_r != '1)) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      if (forced) begin
        cnt_nxt = '0;
      end
    end
  end

  // Report the state after the poll
  always_comb begin
    res.power_state    = mode_nxt;
    res.sleep_request  = req;
    res.forced_wake    = forced;
    res.awake_time_ms  = (a_run_nxt ? now : a_en_nxt) - a_st_nxt;
    res.asleep_time_ms = (s_run_nxt ? now : s_en_nxt) - s_st_nxt;
    res.doze_total     = cnt_nxt;
  end

  // Advance the state once per accepted poll
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_INIT;
      entry_r <= '0;
      hold_r  <= DEF_ACT_RST;
      cnt_r   <= '0;
      a_st_r  <= '0;
      a_en_r  <= '0;
      a_run_r <= 1'b0;
      s_st_r  <= '0;
      s_en_r  <= '0;
      s_run_r <= 1'b0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      entry_r <= entry_nxt;
      hold_r  <= hold_nxt;
      cnt_r   <= cnt_nxt;
      a_st_r  <= a_st_nxt;
      a_en_r  <= a_en_nxt;
      a_run_r <= a_run_nxt;
      s_st_r  <= s_st_nxt;
      s_en_r  <= s_en_nxt;
      s_run_r <= s_run_nxt;
    end
  end

  `ADSC_ASSERT(a_one_watch, clk, rst_n, !(a_run_r && s_run_r))
  `ADSC_ASSERT(a_sleepy_counts, clk, rst_n, (mode_r != MODE_SLEEPY) || s_run_r)
  `ADSC_ASSERT_NEXT(a_hold_disabled, clk, rst_n, step && !cfg.enable, $stable(mode_r))
  `ADSC_ASSERT_NEXT(a_forced_clear, clk, rst_n, step && forced, cnt_r == '0)

endmodule

[hw/rtl/activity_driven_sleep_controller.sv]
// ----------------------------------------------------------------------------
// activity_driven_sleep_controller
// Poll-driven power state machine with doze limit and awake/asleep timers.
// ----------------------------------------------------------------------------
// Channel   Direction  Word
// in_       slave      poll: time stamp and radio activity hold
// out_      master     report: power state, sleep request, timers, doze count
// cfg_      write      setting registers, one per index
//
// A poll is taken into an input register and evaluated there; its report
// lands in the output register, which drives tvalid.
// One poll per cycle is sustained while the output is not stalled; the
// state update is a single pass through the mode compare, the doze-limit
// multiply and the stopwatch subtracts.
// A stalled output holds the report and the poll behind it; in_tready drops
// only when both registers are full. Reset is synchronous.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module activity_driven_sleep_controller (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [31:0] now_ms, [47:32] radio_active
  input  logic [adsc_pkg::IN_W-1:0]    in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [2:0] power_state, [3] sleep_request, [4] forced_wake,
  // [36:5] awake_time_ms, [68:37] asleep_time_ms, [84:69] doze_total, [87:85] zero
  output logic [adsc_pkg::OUT_W-1:0]   out_tdata,
  input  logic                         cfg_we,
  input  logic [adsc_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [adsc_pkg::CFG_DW-1:0]  cfg_wdata
);
  import adsc_pkg::*;

  cfg_t              cfg;
  res_t              res;

  logic              v1_r;
  logic [TIME_W-1:0] now1_r;
  logic [HOLD_W-1:0] radio1_r;
  logic              ov_r;
  logic [OUT_W-1:0]  odata_r;
  logic              adv;
  logic              step;
  logic              take;

  adsc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  adsc_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (step),
    .now   (now1_r),
    .radio (radio1_r),
    .res   (res)
  );

  // Handshake: evaluate when the output register is free or draining
  always_comb begin
    adv       = !ov_r || out_tready;
    step      = v1_r && adv;
    in_tready = !v1_r || adv;
    take      = in_tvalid && in_tready;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_tready) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      now1_r   <= in_tdata[TIME_W-1:0];
      radio1_r <= in_tdata[TIME_W +: HOLD_W];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (step) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      odata_r <= {3'b000, res};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = odata_r;

  `ADSC_ASSERT(a_req_state, clk, rst_n,
    !(out_tvalid && out_tdata[3]) || (out_tdata[2:0] == MODE_DOZE) || out_tdata[4])
  `ADSC_ASSERT(a_forced_state, clk, rst_n,
    !(out_tvalid && out_tdata[4]) || ((out_tdata[2:0] == MODE_ACTIVE) && (out_tdata[84:69] == '0)))
  `ADSC_ASSERT_NEXT(a_stage_hold, clk, rst_n, v1_r && !adv, v1_r && $stable(now1_r))

endmodule

[test/tb_activity_driven_sleep_controller.sv]
// ----------------------------------------------------------------------------
// tb_activity_driven_sleep_controller
// Self-checking bench for the activity-driven sleep controller. A scripted
// walk through every power mode, the doze limit and the timer wrap comes
// first. Random phases under changing settings follow, then one quiet doze
// run under a zero period. Every report word is compared field by
// field with a cycle-free model of the state machine and its stopwatches.
// ----------------------------------------------------------------------------
module tb_activity_driven_sleep_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import adsc_pkg::*;

  localparam int RAND_PHASES  = 16;
  localparam int PHASE_POLLS  = 115;
  localparam int DOZE_RUN     = 128;
  localparam int STALL_LIMIT  = 10000;
  localparam int MAX_REPORTED = 10;

  // One row of the scripted part: a register write or a poll
  typedef struct packed {
    logic              is_cfg;
    cfg_reg_t          idx;
    logic [CFG_DW-1:0] val;
    logic [TIME_W-1:0] now;
    logic [HOLD_W-1:0] radio;
    logic              known;     // expect the cleared report
  } step_row_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_we     = 1'b0;
  logic [ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DW-1:0] cfg_wdata  = '0;

  // Settings as the model sees them
  logic              set_enable  = 1'b0;
  logic [DUTY_W-1:0] set_duty    = DUTY_RST;
  logic [HOLD_W-1:0] set_len     = 16'd100;
  logic [HOLD_W-1:0] set_period  = PERIOD_RST;
  logic [TIME_W-1:0] set_max     = MAX_SLEEP_RST;
  logic [HOLD_W-1:0] set_init    = INIT_HOLD_RST;
  logic [HOLD_W-1:0] set_def     = DEF_ACT_RST;

  // Model state
  pwr_mode_t         mode        = MODE_INIT;
  logic [TIME_W-1:0] entry_ms    = '0;
  logic [HOLD_W-1:0] hold_ms     = DEF_ACT_RST;
  logic [CNT_W-1:0]  dozes       = '0;
  logic [TIME_W-1:0] awake_st    = '0;
  logic [TIME_W-1:0] awake_en    = '0;
  logic              awake_run   = 1'b0;
  logic [TIME_W-1:0] asleep_st   = '0;
  logic [TIME_W-1:0] asleep_en   = '0;
  logic              asleep_run  = 1'b0;

  res_t              report_q[$];
  step_row_t         script[$];
  res_t              got;
  res_t              want;
  int                failures    = 0;
  int                stall_cnt   = 0;
  logic              steady      = 1'b0;
  logic              poll_driven = 1'b0;

  activity_driven_sleep_controller uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Resume the awake stopwatch, keeping the time already counted
  function automatic void resume_awake(logic [TIME_W-1:0] now);
    if (!awake_run) begin
      awake_st  = now - (awake_en - awake_st);
      awake_run = 1'b1;
    end
  endfunction

  // Switch power mode and move the stopwatches along
  function automatic void enter_mode(pwr_mode_t next, logic [TIME_W-1:0] now);
    if (mode == MODE_SLEEPY) begin
      resume_awake(now);
      if (asleep_run) begin
        asleep_en  = now;
        asleep_run = 1'b0;
      end
    end
    mode     = next;
    entry_ms = now;
    resume_awake(now);
    if (next == MODE_SLEEPY) begin
      hold_ms = set_def;
      if (awake_run) begin
        awake_en  = now;
        awake_run = 1'b0;
      end
      if (!asleep_run) begin
        asleep_st  = now - (asleep_en - asleep_st);
        asleep_run = 1'b1;
      end
    end else if (next == MODE_DOZE) begin
      if (dozes != '1) dozes = dozes + CNT_W'(1);
    end
  endfunction

  // Advance the model by one poll and build the report it gives
  function automatic res_t predict_report(logic [TIME_W-1:0] now,
                                          logic [HOLD_W-1:0] radio);
    res_t              r;
    logic [TIME_W-1:0] doze_iv;
    logic [TIME_W-1:0] in_mode;
    logic [63:0]       limit_prod;
    r = '0;
    if (!set_enable) begin
      entry_ms = now;
    end else begin
      doze_iv = TIME_W'(set_period);
      doze_iv = (doze_iv * TIME_W'(set_duty)) / TIME_W'(PCT_SCALE);
      in_mode = now - entry_ms;
      if (doze_iv < 1) doze_iv = 1;
      if (radio != '0 && radio > hold_ms) hold_ms = radio;
      case (mode)
        MODE_INIT: begin
          if (in_mode > TIME_W'(set_init)) enter_mode(MODE_ACTIVE, now);
        end
        MODE_ACTIVE: begin
          if (radio != '0) entry_ms = now;
          else if (in_mode > TIME_W'(hold_ms)) enter_mode(MODE_SOON, now);
        end
        MODE_SOON: begin
          if (radio != '0) enter_mode(MODE_ACTIVE, now);
          else if (in_mode > SOON_DWELL_MS) enter_mode(MODE_SLEEPY, now);
        end
        MODE_SLEEPY: begin
          if (radio != '0) begin
            enter_mode(MODE_ACTIVE, now);
          end else begin
            r.sleep_request = 1'b1;
            limit_prod = 64'(dozes);
            limit_prod = limit_prod * 64'(set_period);
            if (limit_prod > 64'(set_max)) begin
              enter_mode(MODE_ACTIVE, now);
              dozes         = '0;
              r.forced_wake = 1'b1;
            end else begin
              enter_mode(MODE_DOZE, now);
            end
          end
        end
        MODE_DOZE: begin
          if (radio != '0) enter_mode(MODE_ACTIVE, now);
          else if (in_mode >= doze_iv) enter_mode(MODE_SLEEPY, now);
        end
        default: ;
      endcase
    end
    r.power_state    = mode;
    r.awake_time_ms  = (awake_run ? now : awake_en) - awake_st;
    r.asleep_time_ms = (asleep_run ? now : asleep_en) - asleep_st;
    r.doze_total     = dozes;
    return r;
  endfunction

  function automatic step_row_t cfg_step(cfg_reg_t idx, logic [CFG_DW-1:0] val);
    step_row_t s;
    s        = '0;
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.val    = val;
    return s;
  endfunction

  function automatic step_row_t poll_step(logic [TIME_W-1:0] now,
                                          logic [HOLD_W-1:0] radio, logic known);
    step_row_t s;
    s       = '0;
    s.now   = now;
    s.radio = radio;
    s.known = known;
    return s;
  endfunction

  // Hold off the poll stream until every report has come back
  task automatic drain_reports();
    if (poll_driven) begin
      in_tvalid   <= 1'b0;
      poll_driven = 1'b0;
    end
    while (report_q.size() != 0) @(posedge clk);
  endtask

  // Write one setting register and mirror it in the model
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_ENABLE:    set_enable = val[0];
      REG_DUTY:      set_duty   = val[DUTY_W-1:0];
      REG_SLEEP_LEN: set_len    = val[HOLD_W-1:0];
      REG_PERIOD:    set_period = val[HOLD_W-1:0];
      REG_MAX_SLEEP: set_max    = val[TIME_W-1:0];
      REG_INIT_HOLD: set_init   = val[HOLD_W-1:0];
      REG_DEF_ACT:   set_def    = val[HOLD_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one poll word, wait for the handshake, queue its report
  task automatic send_poll(logic [TIME_W-1:0] now, logic [HOLD_W-1:0] radio,
                           logic known);
    logic taken;
    res_t predicted;
    cfg_we <= 1'b0;
    while (!steady && $urandom_range(99) < 13) begin
      if (poll_driven) begin
        in_tvalid   <= 1'b0;
        poll_driven = 1'b0;
      end
      @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= {radio, now};
    poll_driven = 1'b1;
    taken       = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end
    predicted = predict_report(now, radio);
    report_q.push_back(known ? res_t'('0) : predicted);
  endtask

  // Stall the report stream at random, except in the steady stretch
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 13);
  end

  // Check report words and watch for a hung handshake
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[84:0];
        if (report_q.size() == 0) begin
          if (failures < MAX_REPORTED)
            $display("unexpected report word: state %0d req %0b forced %0b",
                     got.power_state, got.sleep_request, got.forced_wake);
          failures++;
        end else begin
          want = report_q.pop_front();
          if (got.power_state !== want.power_state ||
              got.sleep_request !== want.sleep_request ||
              got.forced_wake !== want.forced_wake ||
              got.awake_time_ms !== want.awake_time_ms ||
              got.asleep_time_ms !== want.asleep_time_ms ||
              got.doze_total !== want.doze_total ||
              out_tdata[OUT_W-1:85] !== '0) begin
            if (failures < MAX_REPORTED) begin
              $display("report mismatch: exp state %0d req %0b forced %0b",
                       want.power_state, want.sleep_request, want.forced_wake);
              $display("  exp awake %0d asleep %0d dozes %0d",
                       want.awake_time_ms, want.asleep_time_ms, want.doze_total);
              $display("  got state %0d req %0b forced %0b pad %0h",
                       got.power_state, got.sleep_request, got.forced_wake,
                       out_tdata[OUT_W-1:85]);
              $display("  got awake %0d asleep %0d dozes %0d",
                       got.awake_time_ms, got.asleep_time_ms, got.doze_total);
            end
            failures++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("tb_activity_driven_sleep_controller failed");
        $finish;
      end
    end
  end

  initial begin
    logic [TIME_W-1:0] clock_ms;
    logic [TIME_W-1:0] delta;
    logic [TIME_W-1:0] scale;
    logic [TIME_W-1:0] doze_iv;
    logic [TIME_W-1:0] radio_lim;
    logic [HOLD_W-1:0] radio;
    int                pick;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Disabled polls after reset report the cleared word, wrap at the top
    script.push_back(poll_step(32'h0000_0000, 16'h0000, 1'b1));
    script.push_back(poll_step(32'hFFFF_FFFF, 16'hFFFF, 1'b1));
    script.push_back(cfg_step(REG_DUTY, 32'd10));
    script.push_back(cfg_step(REG_SLEEP_LEN, 32'h0000_FFFF));
    script.push_back(cfg_step(REG_PERIOD, 32'd100));
    script.push_back(cfg_step(REG_MAX_SLEEP, 32'd250));
    script.push_back(cfg_step(REG_INIT_HOLD, 32'd0));
    script.push_back(cfg_step(REG_DEF_ACT, 32'd0));
    script.push_back(cfg_step(REG_ENABLE, 32'd1));
    // Init to active across the timer wrap, then the default hold runs out
    script.push_back(poll_step(32'd5, 16'd0, 1'b0));
    script.push_back(poll_step(32'd5006, 16'd0, 1'b0));
    script.push_back(poll_step(32'd5300, 16'd0, 1'b0));
    script.push_back(poll_step(32'd5507, 16'd0, 1'b0));
    // Sleepy and doze alternate until the doze limit forces a wake
    script.push_back(poll_step(32'd5508, 16'd0, 1'b0));
    script.push_back(poll_step(32'd5517, 16'd0, 1'b0));
    script.push_back(poll_step(32'd5518, 16'd0, 1'b0));
    script.push_back(poll_step(32'd5519, 16'd0, 1'b0));
    script.push_back(poll_step(32'd5529, 16'd0, 1'b0));
    script.push_back(poll_step(32'd5530, 16'd0, 1'b0));
    script.push_back(poll_step(32'd5540, 16'd0, 1'b0));
    script.push_back(poll_step(32'd5541, 16'd0, 1'b0));
    // Largest activity hold, then activity during sleep soon
    script.push_back(poll_step(32'd5542, 16'hFFFF, 1'b0));
    script.push_back(poll_step(32'd5600, 16'd0, 1'b0));
    script.push_back(poll_step(32'd71078, 16'd0, 1'b0));
    script.push_back(poll_step(32'd71100, 16'd1, 1'b0));
    script.push_back(poll_step(32'd136636, 16'd0, 1'b0));
    script.push_back(poll_step(32'd137137, 16'd0, 1'b0));
    // Zero period with duty above a hundred: doze interval raised to one
    script.push_back(cfg_step(REG_PERIOD, 32'd0));
    script.push_back(cfg_step(REG_DUTY, 32'd127));
    script.push_back(cfg_step(REG_MAX_SLEEP, 32'd0));
    script.push_back(poll_step(32'd137138, 16'd0, 1'b0));
    script.push_back(poll_step(32'd137139, 16'd0, 1'b0));
    script.push_back(poll_step(32'd137139, 16'h8000, 1'b0));
    // Disabled poll only restarts the mode timer
    script.push_back(cfg_step(REG_ENABLE, 32'd0));
    script.push_back(poll_step(32'hFFFF_FFF0, 16'd0, 1'b0));
    script.push_back(cfg_step(REG_ENABLE, 32'd1));
    script.push_back(poll_step(32'h0000_0010, 16'd0, 1'b0));

    for (int i = 0; i < script.size(); i++) begin
      if (script[i].is_cfg) begin
        drain_reports();
        write_reg(script[i].idx, script[i].val);
      end else begin
        send_poll(script[i].now, script[i].radio, script[i].known);
      end
    end
    clock_ms = 32'h0000_0010;

    // Random phases, each under fresh settings written while idle
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_reports();
      steady = (p == 2);
      if (p == 0) begin
        write_reg(REG_DUTY, 32'd127);
        write_reg(REG_SLEEP_LEN, 32'h0000_FFFF);
        write_reg(REG_PERIOD, 32'h0000_FFFF);
        write_reg(REG_MAX_SLEEP, 32'hFFFF_FFFF);
        write_reg(REG_INIT_HOLD, 32'h0000_FFFF);
        write_reg(REG_DEF_ACT, 32'h0000_FFFF);
      end else if (p == 1) begin
        write_reg(REG_DUTY, 32'd0);
        write_reg(REG_SLEEP_LEN, 32'd0);
        write_reg(REG_PERIOD, 32'd0);
        write_reg(REG_MAX_SLEEP, 32'd0);
        write_reg(REG_INIT_HOLD, 32'd0);
        write_reg(REG_DEF_ACT, 32'd0);
      end else begin
        write_reg(REG_DUTY, $urandom_range(127));
        write_reg(REG_SLEEP_LEN, $urandom & 32'h0000_FFFF);
        write_reg(REG_PERIOD, ($urandom_range(9) == 0) ?
                  ($urandom & 32'h0000_FFFF) : $urandom_range(600));
        pick = $urandom_range(99);
        if (pick < 60) write_reg(REG_MAX_SLEEP, $urandom_range(3000));
        else if (pick < 85) write_reg(REG_MAX_SLEEP, $urandom);
        else write_reg(REG_MAX_SLEEP, (pick < 92) ? 32'd0 : 32'hFFFF_FFFF);
        write_reg(REG_INIT_HOLD, ($urandom_range(9) == 0) ?
                  ($urandom & 32'h0000_FFFF) : $urandom_range(2000));
        write_reg(REG_DEF_ACT, ($urandom_range(9) == 0) ?
                  ($urandom & 32'h0000_FFFF) : $urandom_range(1500));
      end
      write_reg(REG_ENABLE, (p % 5 != 3) ? 32'd1 : 32'd0);

      // Scale time steps to the longest dwell of these settings
      doze_iv = TIME_W'(set_period);
      doze_iv = (doze_iv * TIME_W'(set_duty)) / TIME_W'(PCT_SCALE);
      scale   = TIME_W'(set_init);
      if (TIME_W'(set_def) > scale) scale = TIME_W'(set_def);
      if (doze_iv > scale) scale = doze_iv;
      radio_lim = (scale < 32'd65535) ? scale + 1 : 32'd65535;

      for (int k = 0; k < PHASE_POLLS; k++) begin
        pick = $urandom_range(99);
        if (pick < 45) delta = $urandom_range(3);
        else if (pick < 80) delta = $urandom_range(scale + 2);
        else if (pick < 94) delta = $urandom_range(2 * scale + 600);
        else if (pick < 98) delta = $urandom_range(140000);
        else delta = $urandom;
        pick = $urandom_range(99);
        if (pick < 75) radio = '0;
        else if (pick < 92) radio = HOLD_W'($urandom_range(radio_lim, 1));
        else radio = HOLD_W'($urandom);
        clock_ms = clock_ms + delta;
        send_poll(clock_ms, radio, 1'b0);
      end
    end

    // Quiet doze run; a zero period never forces a wake
    drain_reports();
    steady = 1'b1;
    write_reg(REG_PERIOD, 32'd0);
    write_reg(REG_MAX_SLEEP, 32'd0);
    write_reg(REG_INIT_HOLD, 32'd0);
    write_reg(REG_DEF_ACT, 32'd0);
    write_reg(REG_DUTY, $urandom_range(127));
    write_reg(REG_SLEEP_LEN, $urandom & 32'h0000_FFFF);
    write_reg(REG_ENABLE, 32'd1);
    for (int k = 0; k < DOZE_RUN; k++) begin
      clock_ms = clock_ms + ((k < 4) ? 32'd70000 : 32'd1);
      send_poll(clock_ms, 16'd0, 1'b0);
    end
    steady = 1'b0;

    drain_reports();
    repeat (8) @(posedge clk);
    if (failures == 0 && report_q.size() == 0) begin
      $display("tb_activity_driven_sleep_controller passed");
    end else begin
      $display("tb_activity_driven_sleep_controller failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/adsc_pkg.sv
hw/rtl/adsc_cfg.sv
hw/rtl/adsc_fsm.sv
hw/rtl/activity_driven_sleep_controller.sv
test/tb_activity_driven_sleep_controller.sv
